// File: rtl/core/tour_move_engine_defines.svh
// ---------------------------------------------------------------------------
// tour_move_engine_defines
// assertion macros used by the checker file tme_checker
// ---------------------------------------------------------------------------
`ifndef TOUR_MOVE_ENGINE_DEFINES_SVH
`define TOUR_MOVE_ENGINE_DEFINES_SVH

// same-cycle implication
`define TME_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tour_move_engine check failed");

// next-cycle implication
`define TME_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tour_move_engine check failed");

`endif

// File: rtl/core/tme_pkg.sv
// ---------------------------------------------------------------------------
// tme_pkg
// shared codes, widths and control structs of the tour move engine
// ---------------------------------------------------------------------------
package tme_pkg;

  localparam int MAX_CITIES_DEF = 256;
  localparam int DIST_BITS_DEF  = 24;
  localparam int POS_W          = 9;
  localparam int CITY_W         = 8;
  localparam int LEN_W          = 8;
  localparam int COST_W         = 40;
  localparam int DELTA_W        = 27;
  localparam int FUNC_W         = 3;
  localparam int STAT_W         = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD_DIST  = 3'd0,
    FN_LOAD_ROUTE = 3'd1,
    FN_LOAD_COST  = 3'd2,
    FN_SWAP       = 3'd3,
    FN_TWO_OPT    = 3'd4,
    FN_OR_OPT     = 3'd5,
    FN_DBRIDGE    = 3'd6,
    FN_READ_ROUTE = 3'd7
  } func_e;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERLAP = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_SAT     = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       simple;
    logic       clr_acc;
    logic       pair_issue;
    logic [2:0] slot;
    logic       rev_load;
    logic [1:0] rev_idx;
    logic       rev_read;
    logic       rev_wr_a;
    logic       rev_wr_b;
    logic       rev_step;
    logic       apply_cost;
    logic       finish;
  } tme_cmd_t;

  typedef struct packed {
    logic       is_move;
    logic       apply;
    logic [2:0] last_slot;
    logic       rev_active;
  } tme_stat_t;

endpackage

// File: rtl/core/tme_ctrl.sv
// ---------------------------------------------------------------------------
// tme_ctrl
// sequencer: decode, distance evaluation, segment reversals, result
// ---------------------------------------------------------------------------
module tme_ctrl
  import tme_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  tme_stat_t stat_i,
  output tme_cmd_t  cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DECODE = 12'b0000_0000_0010,
    S_EVAL   = 12'b0000_0000_0100,
    S_DRAIN1 = 12'b0000_0000_1000,
    S_DRAIN2 = 12'b0000_0001_0000,
    S_SUM    = 12'b0000_0010_0000,
    S_RLOAD  = 12'b0000_0100_0000,
    S_RCHK   = 12'b0000_1000_0000,
    S_RRD    = 12'b0001_0000_0000,
    S_RW1    = 12'b0010_0000_0000,
    S_RW2    = 12'b0100_0000_0000,
    S_FIN    = 12'b1000_0000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] slot_q, slot_d;
  logic [1:0] ridx_q, ridx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= 3'd0;
      ridx_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      ridx_q  <= ridx_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    slot_d        = slot_q;
    ridx_d        = ridx_q;
    cmd_o         = '0;
    cmd_o.slot    = slot_q;
    cmd_o.rev_idx = ridx_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_move) begin
          cmd_o.clr_acc = 1'b1;
          slot_d        = 3'd0;
          state_d       = S_EVAL;
        end else begin
          cmd_o.simple = 1'b1;
          state_d      = S_FIN;
        end
      end
      S_EVAL: begin
        cmd_o.pair_issue = 1'b1;
        if (slot_q == stat_i.last_slot) begin
          state_d = S_DRAIN1;
        end else begin
          slot_d = slot_q + 3'd1;
        end
      end
      S_DRAIN1: state_d = S_DRAIN2;
      S_DRAIN2: state_d = S_SUM;
      S_SUM: begin
        if (stat_i.apply) begin
          cmd_o.apply_cost = 1'b1;
          ridx_d           = 2'd0;
          state_d          = S_RLOAD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_RLOAD: begin
        cmd_o.rev_load = 1'b1;
        state_d        = S_RCHK;
      end
      S_RCHK: begin
        if (stat_i.rev_active) begin
          state_d = S_RRD;
        end else if (ridx_q == 2'd3) begin
          state_d = S_FIN;
        end else begin
          ridx_d  = ridx_q + 2'd1;
          state_d = S_RLOAD;
        end
      end
      S_RRD: begin
        cmd_o.rev_read = 1'b1;
        state_d        = S_RW1;
      end
      S_RW1: begin
        cmd_o.rev_wr_a = 1'b1;
        state_d        = S_RW2;
      end
      S_RW2: begin
        cmd_o.rev_wr_b = 1'b1;
        cmd_o.rev_step = 1'b1;
        state_d        = S_RCHK;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: rtl/core/tme_dpath.sv
// ---------------------------------------------------------------------------
// tme_dpath
// distance matrix, route store, cost, evaluation pipe and reversal pointers
// ---------------------------------------------------------------------------
module tme_dpath
  import tme_pkg::*;
#(
  parameter int MAX_CITIES = MAX_CITIES_DEF,
  parameter int DIST_BITS  = DIST_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [POS_W-1:0]           cfg_wdata_i,
  input  logic [FUNC_W-1:0]          func_i,
  input  logic                       apply_i,
  input  logic [POS_W-1:0]           pos_i_i,
  input  logic [POS_W-1:0]           pos_j_i,
  input  logic [POS_W-1:0]           pos_i_end_i,
  input  logic [POS_W-1:0]           pos_j_end_i,
  input  logic [LEN_W-1:0]           seg_len_i,
  input  logic [CITY_W-1:0]          city_row_i,
  input  logic [CITY_W-1:0]          city_col_i,
  input  logic [DIST_BITS-1:0]       distance_i,
  input  logic [CITY_W-1:0]          route_city_i,
  input  logic [COST_W-1:0]          cost_load_i,
  input  tme_cmd_t                   cmd_i,
  output tme_stat_t                  stat_o,
  output logic                       result_valid_o,
  output logic signed [DELTA_W-1:0]  delta_o,
  output logic [COST_W-1:0]          tour_cost_out_o,
  output logic [CITY_W-1:0]          city_out_o,
  output logic [STAT_W-1:0]          status_o
);

  localparam int PW = $clog2(MAX_CITIES + 1);
  localparam int MW = $clog2(MAX_CITIES * MAX_CITIES);
  localparam int AW = DIST_BITS + 4;
  localparam int EW = (AW > DELTA_W) ? AW : DELTA_W;
  localparam logic signed [EW-1:0] DMAX = EW'(67108863);
  localparam logic signed [EW-1:0] DMIN = -EW'(67108864);
  localparam int XW = 10;

  logic [DIST_BITS-1:0] dmem [MAX_CITIES*MAX_CITIES];
  logic [CITY_W-1:0]    rmem [MAX_CITIES+1];

  logic [POS_W-1:0]     cfg_q;
  logic [FUNC_W-1:0]    func_q;
  logic                 apply_q;
  logic [XW-1:0]        i_q, j_q, ie_q, je_q;
  logic [LEN_W-1:0]     len_q;
  logic [CITY_W-1:0]    row_q, col_q, rcity_q;
  logic [DIST_BITS-1:0] dist_q;
  logic [COST_W-1:0]    cload_q, cost_q;
  logic                 sat_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 9'd256;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      apply_q <= apply_i;
      i_q     <= {1'b0, pos_i_i};
      j_q     <= {1'b0, pos_j_i};
      ie_q    <= {1'b0, pos_i_end_i};
      je_q    <= {1'b0, pos_j_end_i};
      len_q   <= seg_len_i;
      row_q   <= city_row_i;
      col_q   <= city_col_i;
      dist_q  <= distance_i;
      rcity_q <= route_city_i;
      cload_q <= cost_load_i;
    end
  end

  // position arithmetic and range checks
  logic [XW-1:0] l_pos, lm1, im1, ip1, jm1, jp1, iem1, jem1, last, lastp1;
  logic          range_ok, overlap, move_fn, swap_adj, db_adj;

  always_comb begin
    if (cfg_q < 9'd4) begin
      l_pos = 10'd4;
    end else if (32'(cfg_q) > MAX_CITIES) begin
      l_pos = 10'(MAX_CITIES);
    end else begin
      l_pos = {1'b0, cfg_q};
    end
  end

  assign lm1      = l_pos - 10'd1;
  assign im1      = i_q - 10'd1;
  assign ip1      = i_q + 10'd1;
  assign jm1      = j_q - 10'd1;
  assign jp1      = j_q + 10'd1;
  assign iem1     = ie_q - 10'd1;
  assign jem1     = je_q - 10'd1;
  assign lastp1   = i_q + {2'b00, len_q};
  assign last     = lastp1 - 10'd1;
  assign swap_adj = (j_q == ip1);
  assign db_adj   = (ie_q == j_q);

  always_comb begin
    range_ok = 1'b1;
    overlap  = 1'b0;
    move_fn  = 1'b0;
    case (func_e'(func_q))
      FN_LOAD_DIST:  range_ok = (32'(row_q) < MAX_CITIES) && (32'(col_q) < MAX_CITIES);
      FN_LOAD_ROUTE: range_ok = (i_q <= l_pos);
      FN_LOAD_COST:  range_ok = 1'b1;
      FN_READ_ROUTE: range_ok = (i_q <= l_pos);
      FN_SWAP: begin
        move_fn  = 1'b1;
        range_ok = (i_q != 10'd0) && (i_q < j_q) && (j_q <= lm1);
      end
      FN_TWO_OPT: begin
        move_fn  = 1'b1;
        range_ok = (i_q != 10'd0) && (i_q <= j_q) && (j_q <= lm1);
      end
      FN_OR_OPT: begin
        move_fn  = 1'b1;
        range_ok = (len_q != '0) && (i_q != 10'd0) && (lastp1 <= l_pos)
                   && (j_q != 10'd0) && (j_q <= l_pos);
        overlap  = (j_q >= i_q) && (j_q <= lastp1);
      end
      FN_DBRIDGE: begin
        move_fn  = 1'b1;
        range_ok = (i_q != 10'd0) && (i_q < ie_q) && (ie_q <= j_q) && (j_q < je_q)
                   && (je_q <= l_pos);
      end
      default: range_ok = 1'b0;
    endcase
  end

  // edge lists: removed edges first, then added edges
  logic [XW-1:0] pp [8];
  logic [XW-1:0] qq [8];
  logic [7:0]    negm;
  logic [2:0]    last_slot;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pp[k] = i_q;
      qq[k] = im1;
    end
    negm      = 8'b0000_1111;
    last_slot = 3'd7;
    case (func_e'(func_q))
      FN_SWAP: begin
        if (swap_adj) begin
          pp[1] = j_q;   qq[1] = jp1;
          pp[2] = j_q;   qq[2] = im1;
          pp[3] = jp1;   qq[3] = i_q;
          negm      = 8'b0000_0011;
          last_slot = 3'd3;
        end else begin
          pp[0] = i_q;   qq[0] = ip1;
          pp[1] = i_q;   qq[1] = im1;
          pp[2] = j_q;   qq[2] = jp1;
          pp[3] = j_q;   qq[3] = jm1;
          pp[4] = ip1;   qq[4] = j_q;
          pp[5] = j_q;   qq[5] = im1;
          pp[6] = jp1;   qq[6] = i_q;
          pp[7] = i_q;   qq[7] = jm1;
        end
      end
      FN_TWO_OPT: begin
        pp[1] = j_q;   qq[1] = jp1;
        pp[2] = i_q;   qq[2] = jp1;
        pp[3] = j_q;   qq[3] = im1;
        negm      = 8'b0000_0011;
        last_slot = 3'd3;
      end
      FN_OR_OPT: begin
        pp[1] = last;  qq[1] = lastp1;
        pp[2] = j_q;   qq[2] = jm1;
        pp[3] = im1;   qq[3] = lastp1;
        pp[4] = i_q;   qq[4] = jm1;
        pp[5] = last;  qq[5] = j_q;
        negm      = 8'b0000_0111;
        last_slot = 3'd5;
      end
      FN_DBRIDGE: begin
        if (db_adj) begin
          pp[1] = iem1;  qq[1] = j_q;
          pp[2] = je_q;  qq[2] = jem1;
          pp[3] = im1;   qq[3] = j_q;
          pp[4] = jem1;  qq[4] = i_q;
          pp[5] = iem1;  qq[5] = je_q;
          negm      = 8'b0000_0111;
          last_slot = 3'd5;
        end else begin
          pp[1] = ie_q;  qq[1] = iem1;
          pp[2] = j_q;   qq[2] = jm1;
          pp[3] = je_q;  qq[3] = jem1;
          pp[4] = im1;   qq[4] = j_q;
          pp[5] = jem1;  qq[5] = ie_q;
          pp[6] = jm1;   qq[6] = i_q;
          pp[7] = iem1;  qq[7] = je_q;
        end
      end
      default: last_slot = 3'd7;
    endcase
  end

  // reversal spans, empty span is lo above hi
  logic [XW-1:0] rlo, rhi, ra_q, rb_q;

  always_comb begin
    rlo = 10'd1;
    rhi = 10'd0;
    case (func_e'(func_q))
      FN_SWAP: begin
        case (cmd_i.rev_idx)
          2'd0:    begin rlo = i_q; rhi = j_q; end
          2'd1:    begin rlo = ip1; rhi = jm1; end
          default: begin rlo = 10'd1; rhi = 10'd0; end
        endcase
      end
      FN_TWO_OPT: begin
        if (cmd_i.rev_idx == 2'd0) begin
          rlo = i_q;
          rhi = j_q;
        end
      end
      FN_OR_OPT: begin
        if (j_q < i_q) begin
          case (cmd_i.rev_idx)
            2'd0:    begin rlo = j_q; rhi = im1;  end
            2'd1:    begin rlo = i_q; rhi = last; end
            2'd2:    begin rlo = j_q; rhi = last; end
            default: begin rlo = 10'd1; rhi = 10'd0; end
          endcase
        end else begin
          case (cmd_i.rev_idx)
            2'd0:    begin rlo = i_q;    rhi = last; end
            2'd1:    begin rlo = lastp1; rhi = jm1;  end
            2'd2:    begin rlo = i_q;    rhi = jm1;  end
            default: begin rlo = 10'd1;  rhi = 10'd0; end
          endcase
        end
      end
      FN_DBRIDGE: begin
        case (cmd_i.rev_idx)
          2'd0:    begin rlo = i_q;  rhi = iem1; end
          2'd1:    begin rlo = ie_q; rhi = jm1;  end
          2'd2:    begin rlo = j_q;  rhi = jem1; end
          default: begin rlo = i_q;  rhi = jem1; end
        endcase
      end
      default: rlo = 10'd1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rev_load) begin
      ra_q <= rlo;
      rb_q <= rhi;
    end else if (cmd_i.rev_step) begin
      ra_q <= ra_q + 10'd1;
      rb_q <= rb_q - 10'd1;
    end
  end

  // route store
  logic              rd_en, rwe, is_read, is_lroute, is_ldist;
  logic [XW-1:0]     raddr_a, raddr_b, rwaddr;
  logic [CITY_W-1:0] rwdata, rd_a, rd_b;

  assign is_read   = (func_q == FN_READ_ROUTE);
  assign is_lroute = (func_q == FN_LOAD_ROUTE);
  assign is_ldist  = (func_q == FN_LOAD_DIST);
  assign rd_en     = cmd_i.pair_issue | cmd_i.rev_read | (cmd_i.simple & is_read);
  assign raddr_a   = cmd_i.pair_issue ? pp[cmd_i.slot] : (cmd_i.rev_read ? ra_q : i_q);
  assign raddr_b   = cmd_i.pair_issue ? qq[cmd_i.slot] : rb_q;
  assign rwe       = (cmd_i.simple & is_lroute & range_ok) | cmd_i.rev_wr_a | cmd_i.rev_wr_b;
  assign rwaddr    = cmd_i.rev_wr_a ? ra_q : (cmd_i.rev_wr_b ? rb_q : i_q);
  assign rwdata    = cmd_i.rev_wr_a ? rd_b : (cmd_i.rev_wr_b ? rd_a : rcity_q);

  always_ff @(posedge clk_i) begin
    if (rwe) begin
      rmem[PW'(rwaddr)] <= rwdata;
    end
    if (rd_en) begin
      rd_a <= rmem[PW'(raddr_a)];
      rd_b <= rmem[PW'(raddr_b)];
    end
  end

  // distance matrix and evaluation pipe
  logic                 v1_q, n1_q, v2_q, n2_q, z2_q, dwe;
  logic [MW-1:0]        maddr, mwaddr;
  logic [DIST_BITS-1:0] md_q;
  logic signed [AW-1:0] acc_q, term;

  assign maddr  = MW'(rd_a) * MW'(MAX_CITIES) + MW'(rd_b);
  assign mwaddr = MW'(row_q) * MW'(MAX_CITIES) + MW'(col_q);
  assign dwe    = cmd_i.simple & is_ldist & range_ok;

  always_ff @(posedge clk_i) begin
    if (dwe) begin
      dmem[mwaddr] <= dist_q;
    end
    if (v1_q) begin
      md_q <= dmem[maddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.pair_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q <= negm[cmd_i.slot];
    n2_q <= n1_q;
    z2_q <= (32'(rd_a) >= MAX_CITIES) || (32'(rd_b) >= MAX_CITIES);
  end

  assign term = z2_q ? '0 : $signed(AW'(md_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= n2_q ? (acc_q - term) : (acc_q + term);
    end
  end

  logic signed [EW-1:0]      acc_ext;
  logic signed [DELTA_W-1:0] delta_sat;
  logic signed [COST_W+1:0]  new_cost;
  logic                      is_move;

  assign acc_ext = EW'(acc_q);

  always_comb begin
    if (acc_ext > DMAX) begin
      delta_sat = DELTA_W'(DMAX);
    end else if (acc_ext < DMIN) begin
      delta_sat = DELTA_W'(DMIN);
    end else begin
      delta_sat = DELTA_W'(acc_ext);
    end
  end

  assign new_cost = $signed({2'b00, cost_q}) + (COST_W+2)'(delta_sat);
  assign is_move  = move_fn & range_ok & ~overlap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q <= '0;
      sat_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        sat_q <= 1'b0;
      end
      if (cmd_i.simple && (func_q == FN_LOAD_COST)) begin
        cost_q <= cload_q;
      end else if (cmd_i.apply_cost) begin
        if (new_cost < 0) begin
          cost_q <= '0;
          sat_q  <= 1'b1;
        end else if (new_cost[COST_W+1:COST_W] != 2'b00) begin
          cost_q <= '1;
          sat_q  <= 1'b1;
        end else begin
          cost_q <= new_cost[COST_W-1:0];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      delta_o         <= is_move ? delta_sat : '0;
      tour_cost_out_o <= cost_q;
      city_out_o      <= (is_read && range_ok) ? rd_a : '0;
      if (!range_ok) begin
        status_o <= ST_RANGE;
      end else if (overlap) begin
        status_o <= ST_OVERLAP;
      end else if (sat_q) begin
        status_o <= ST_SAT;
      end else begin
        status_o <= ST_OK;
      end
    end
  end

  assign stat_o.is_move    = is_move;
  assign stat_o.apply      = apply_q;
  assign stat_o.last_slot  = last_slot;
  assign stat_o.rev_active = (ra_q < rb_q);

endmodule

// File: rtl/core/tour_move_engine.sv
// ---------------------------------------------------------------------------
// tour_move_engine
// local-search move engine for a closed tour: loads, reads, swap, 2-opt,
// or-opt and double-bridge moves with cost change and in-place apply
// ---------------------------------------------------------------------------
// channel  | handshake                  | payload
// ---------+----------------------------+----------------------------------
// config   | cfg_we_i                   | cfg_wdata_i (last route position)
// item in  | start & !busy              | func_i .. cost_load_i
// item out | result_valid_o (one cycle) | delta_o, tour_cost_out_o, city_out_o,
//          |                            | status_o
//
// loads, reads and rejected moves: result after the decode and finish states
// move evaluation: a distance-matrix lookup for every removed and added edge
// apply: four span reversals on the route port (some empty), each swapped
//   pair read in state S_RRD and written in states S_RW1 and S_RW2
// reset inits control, cost, saturation flag, cfg (256) only; matrix, route garbage until loaded
// the receiver cannot stall; busy stays high until the result strobe
// ---------------------------------------------------------------------------
module tour_move_engine
  import tme_pkg::*;
#(
  parameter int MAX_CITIES = MAX_CITIES_DEF,
  parameter int DIST_BITS  = DIST_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [POS_W-1:0]          cfg_wdata_i,
  input  logic                      start,
  output logic                      busy,
  input  logic [FUNC_W-1:0]         func_i,
  input  logic                      apply_i,
  input  logic [POS_W-1:0]          pos_i_i,
  input  logic [POS_W-1:0]          pos_j_i,
  input  logic [POS_W-1:0]          pos_i_end_i,
  input  logic [POS_W-1:0]          pos_j_end_i,
  input  logic [LEN_W-1:0]          seg_len_i,
  input  logic [CITY_W-1:0]         city_row_i,
  input  logic [CITY_W-1:0]         city_col_i,
  input  logic [DIST_BITS-1:0]      distance_i,
  input  logic [CITY_W-1:0]         route_city_i,
  input  logic [COST_W-1:0]         cost_load_i,
  output logic                      result_valid_o,
  output logic signed [DELTA_W-1:0] delta_o,
  output logic [COST_W-1:0]         tour_cost_out_o,
  output logic [CITY_W-1:0]         city_out_o,
  output logic [STAT_W-1:0]         status_o
);

  tme_cmd_t  cmd;
  tme_stat_t stat;

  tme_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tme_dpath #(
    .MAX_CITIES (MAX_CITIES),
    .DIST_BITS  (DIST_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .apply_i         (apply_i),
    .pos_i_i         (pos_i_i),
    .pos_j_i         (pos_j_i),
    .pos_i_end_i     (pos_i_end_i),
    .pos_j_end_i     (pos_j_end_i),
    .seg_len_i       (seg_len_i),
    .city_row_i      (city_row_i),
    .city_col_i      (city_col_i),
    .distance_i      (distance_i),
    .route_city_i    (route_city_i),
    .cost_load_i     (cost_load_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .result_valid_o  (result_valid_o),
    .delta_o         (delta_o),
    .tour_cost_out_o (tour_cost_out_o),
    .city_out_o      (city_out_o),
    .status_o        (status_o)
  );

endmodule

// File: rtl/core/tme_checker.sv
// ---------------------------------------------------------------------------
// tme_checker
// port-level checks of the tour move engine, bound to the top level
// ---------------------------------------------------------------------------
`include "tour_move_engine_defines.svh"

module tme_checker
  import tme_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      result_valid_o,
  input logic signed [DELTA_W-1:0] delta_o,
  input logic [CITY_W-1:0]         city_out_o,
  input logic [STAT_W-1:0]         status_o
);

  `TME_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `TME_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o)
  `TME_ASSERT_NOW(a_delta_status, result_valid_o && (delta_o != '0),
                  (status_o == ST_OK) || (status_o == ST_SAT))
  `TME_ASSERT_NOW(a_city_status, result_valid_o && (city_out_o != '0), status_o == ST_OK)

endmodule

bind tour_move_engine tme_checker u_tme_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .delta_o        (delta_o),
  .city_out_o     (city_out_o),
  .status_o       (status_o)
);

// File: sim/tour_move_engine_test.sv
// ----------------------------------------------------------------------------
// tour_move_engine_test
// self-checking bench for the tour move engine: loads a small city set into
// the distance matrix, loads the route, then runs directed and random loads,
// reads and swap, 2-opt, or-opt and double-bridge moves over several tour
// lengths; a local tour model predicts every result and the monitor checks it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tour_move_engine_test;
  import tme_pkg::*;

  localparam int LIMIT = 4000000;

  typedef struct {
    func_e       func;
    logic        apply;
    logic [8:0]  pi, pj, pie, pje;
    logic [7:0]  len, row, col;
    logic [23:0] dval;
    logic [7:0]  rcity;
    logic [39:0] cload;
  } move_item_t;

  typedef struct {
    logic signed [26:0] delta;
    logic [39:0]        cost;
    logic [7:0]         city;
    logic [1:0]         status;
  } move_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func_d = '0;
  logic apply_d = 1'b0;
  logic [8:0] pi_d = '0, pj_d = '0, pie_d = '0, pje_d = '0;
  logic [7:0] len_d = '0, row_d = '0, col_d = '0, rcity_d = '0;
  logic [23:0] dist_d = '0;
  logic [39:0] cload_d = '0;
  logic result_valid;
  logic signed [26:0] delta_o;
  logic [39:0] cost_o;
  logic [7:0] city_o;
  logic [1:0] status_o;

  move_item_t pend_q[$];
  move_res_t  exp_q[$];
  move_item_t cur;
  int gap = 0;
  int errors = 0;
  int cycles = 0;

  // tour model state
  logic [23:0] dmat[65536];
  logic [7:0]  route_st[257];
  logic [39:0] cost_m = '0;
  int          last_m = 256;

  tour_move_engine u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .start(start), .busy(busy), .func_i(func_d), .apply_i(apply_d),
    .pos_i_i(pi_d), .pos_j_i(pj_d), .pos_i_end_i(pie_d), .pos_j_end_i(pje_d),
    .seg_len_i(len_d), .city_row_i(row_d), .city_col_i(col_d),
    .distance_i(dist_d), .route_city_i(rcity_d), .cost_load_i(cload_d),
    .result_valid_o(result_valid), .delta_o(delta_o), .tour_cost_out_o(cost_o),
    .city_out_o(city_o), .status_o(status_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint edge_len(int p, int q);
    return longint'(dmat[{route_st[p], route_st[q]}]);
  endfunction

  function automatic move_res_t predict_move(move_item_t it);
    move_res_t r;
    logic [7:0] old[257];
    int i, j, ie, je, len, L, n, k;
    longint add, sub, d, nc;
    bit mv;
    i = it.pi; j = it.pj; ie = it.pie; je = it.pje; len = it.len; L = last_m;
    add = 0; sub = 0; d = 0; mv = 0;
    r.city = '0; r.status = ST_OK;
    case (it.func)
      FN_LOAD_DIST: dmat[{it.row, it.col}] = it.dval;
      FN_LOAD_ROUTE: begin
        if (i > L) r.status = ST_RANGE;
        else route_st[i] = it.rcity;
      end
      FN_LOAD_COST: cost_m = it.cload;
      FN_READ_ROUTE: begin
        if (i > L) r.status = ST_RANGE;
        else r.city = route_st[i];
      end
      FN_SWAP: begin
        if (i < 1 || i >= j || j > L - 1) r.status = ST_RANGE;
        else begin
          mv = 1;
          if (i + 1 == j) begin
            sub = edge_len(i, i-1) + edge_len(j, j+1);
            add = edge_len(j, i-1) + edge_len(j+1, i);
          end else begin
            sub = edge_len(i, i+1) + edge_len(i, i-1) + edge_len(j, j+1) + edge_len(j, j-1);
            add = edge_len(i+1, j) + edge_len(j, i-1) + edge_len(j+1, i) + edge_len(i, j-1);
          end
        end
      end
      FN_TWO_OPT: begin
        if (i < 1 || i > j || j > L - 1) r.status = ST_RANGE;
        else begin
          mv = 1;
          sub = edge_len(i, i-1) + edge_len(j, j+1);
          add = edge_len(i, j+1) + edge_len(j, i-1);
        end
      end
      FN_OR_OPT: begin
        if (len < 1 || i < 1 || i + len > L || j < 1 || j > L) r.status = ST_RANGE;
        else if (j >= i && j <= i + len) r.status = ST_OVERLAP;
        else begin
          mv = 1;
          n = i + len - 1;
          sub = edge_len(i, i-1) + edge_len(n, n+1) + edge_len(j, j-1);
          add = edge_len(i-1, n+1) + edge_len(i, j-1) + edge_len(n, j);
        end
      end
      default: begin
        if (i < 1 || i >= ie || ie > j || j >= je || je > L) r.status = ST_RANGE;
        else begin
          mv = 1;
          if (ie == j) begin
            sub = edge_len(i, i-1) + edge_len(ie-1, j) + edge_len(je, je-1);
            add = edge_len(i-1, j) + edge_len(je-1, i) + edge_len(ie-1, je);
          end else begin
            sub = edge_len(i, i-1) + edge_len(ie, ie-1) + edge_len(j, j-1) + edge_len(je, je-1);
            add = edge_len(i-1, j) + edge_len(je-1, ie) + edge_len(j-1, i) + edge_len(ie-1, je);
          end
        end
      end
    endcase
    if (mv) begin
      d = add - sub;
      if (d > 67108863) d = 67108863;
      if (d < -67108864) d = -67108864;
      if (it.apply) begin
        nc = longint'(cost_m) + d;
        if (nc < 0) begin
          nc = 0; r.status = ST_SAT;
        end
        if (nc > 64'hFF_FFFF_FFFF) begin
          nc = 64'hFF_FFFF_FFFF; r.status = ST_SAT;
        end
        cost_m = nc[39:0];
        old = route_st;
        case (it.func)
          FN_SWAP: begin
            route_st[i] = old[j]; route_st[j] = old[i];
          end
          FN_TWO_OPT: for (k = i; k <= j; k++) route_st[k] = old[i + j - k];
          FN_OR_OPT: begin
            if (j < i) begin
              for (k = 0; k < len; k++) route_st[j + k] = old[i + k];
              for (k = 0; k < i - j; k++) route_st[j + len + k] = old[j + k];
            end else begin
              for (k = 0; k < j - i - len; k++) route_st[i + k] = old[i + len + k];
              for (k = 0; k < len; k++) route_st[j - len + k] = old[i + k];
            end
          end
          default: begin
            n = i;
            for (k = j; k < je; k++) route_st[n++] = old[k];
            for (k = ie; k < j; k++) route_st[n++] = old[k];
            for (k = i; k < ie; k++) route_st[n++] = old[k];
          end
        endcase
      end
    end
    r.delta = d[26:0];
    r.cost = cost_m;
    return r;
  endfunction

  function automatic int next_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) exp_q.push_back(predict_move(cur));
      if (!start || !busy) begin
        if (start) gap = next_gap();
        if (gap > 0) begin
          gap--;
          start <= 1'b0;
        end else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          func_d <= cur.func; apply_d <= cur.apply;
          pi_d <= cur.pi; pj_d <= cur.pj; pie_d <= cur.pie; pje_d <= cur.pje;
          len_d <= cur.len; row_d <= cur.row; col_d <= cur.col; dist_d <= cur.dval;
          rcity_d <= cur.rcity; cload_d <= cur.cload;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    move_res_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_ni && result_valid) begin
      if (exp_q.size() == 0) begin
        $display("%0t unexpected result delta %0d cost %0h", $time, delta_o, cost_o);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (e.delta !== delta_o) begin
          $display("%0t delta expected %0d actual %0d", $time, e.delta, delta_o);
          errors++;
        end
        if (e.cost !== cost_o) begin
          $display("%0t cost expected %0h actual %0h", $time, e.cost, cost_o);
          errors++;
        end
        if (e.city !== city_o) begin
          $display("%0t city expected %0d actual %0d", $time, e.city, city_o);
          errors++;
        end
        if (e.status !== status_o) begin
          $display("%0t status expected %0d actual %0d", $time, e.status, status_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [7:0] pick_city();
    int k;
    k = $urandom_range(0, 15);
    return (k < 8) ? 8'(k) : 8'(240 + k);
  endfunction

  function automatic move_item_t blank_item(func_e f);
    move_item_t it;
    it.func = f; it.apply = 1'($urandom_range(0, 1));
    it.pi = 9'($urandom); it.pj = 9'($urandom); it.pie = 9'($urandom);
    it.pje = 9'($urandom);
    it.len = 8'($urandom); it.row = 8'($urandom); it.col = 8'($urandom);
    it.dval = 24'($urandom);
    it.rcity = pick_city(); it.cload = 40'({$urandom, $urandom});
    return it;
  endfunction

  task automatic push_item(func_e f, int a, int b, int c, int d, int len, bit ap);
    move_item_t it;
    it = blank_item(f);
    it.pi = 9'(a); it.pj = 9'(b); it.pie = 9'(c); it.pje = 9'(d);
    it.len = 8'(len); it.apply = ap;
    pend_q.push_back(it);
  endtask

  task automatic push_cost(logic [39:0] v);
    move_item_t it;
    it = blank_item(FN_LOAD_COST);
    it.cload = v;
    pend_q.push_back(it);
  endtask

  task automatic add_random(int n);
    move_item_t it;
    int L, p, i, j, ie, je, len;
    for (int k = 0; k < n; k++) begin
      L = last_m;
      p = $urandom_range(0, 99);
      it = blank_item(func_e'($urandom_range(0, 7)));
      if (p < 85) begin
        it.func = func_e'($urandom_range(3, 6));
        case (it.func)
          FN_SWAP: begin
            i = $urandom_range(1, L - 2);
            j = ($urandom_range(0, 2) == 0) ? i + 1 : $urandom_range(i + 1, L - 1);
            it.pi = 9'(i); it.pj = 9'(j);
          end
          FN_TWO_OPT: begin
            i = $urandom_range(1, L - 1);
            it.pi = 9'(i); it.pj = 9'($urandom_range(i, L - 1));
          end
          FN_OR_OPT: begin
            i = $urandom_range(1, L - 1);
            len = $urandom_range(1, (L - i > 255) ? 255 : L - i);
            j = $urandom_range(1, L);
            if (j >= i && j <= i + len && $urandom_range(0, 3) != 0)
              j = (i > 1) ? $urandom_range(1, i - 1) : j;
            it.pi = 9'(i); it.len = 8'(len); it.pj = 9'(j);
          end
          default: begin
            i = $urandom_range(1, L - 2);
            ie = $urandom_range(i + 1, L - 1);
            j = ($urandom_range(0, 2) == 0) ? ie : $urandom_range(ie, L - 1);
            je = $urandom_range(j + 1, L);
            it.pi = 9'(i); it.pie = 9'(ie); it.pj = 9'(j); it.pje = 9'(je);
          end
        endcase
      end else if (p < 90) begin
        it.func = FN_READ_ROUTE;
        it.pi = 9'($urandom_range(0, L));
      end else if (p < 93) begin
        it.func = FN_LOAD_DIST;
        it.row = pick_city(); it.col = pick_city();
      end
      pend_q.push_back(it);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || exp_q.size() != 0 || start);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_last_pos(logic [8:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    last_m = (v < 4) ? 4 : (v > 256) ? 256 : int'(v);
  endtask

  initial begin
    move_item_t it;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_last_pos(9'd511);
    // matrix over the city set, some extremes
    for (int a = 0; a < 16; a++) begin
      for (int b = 0; b < 16; b++) begin
        it = blank_item(FN_LOAD_DIST);
        it.row = (a < 8) ? 8'(a) : 8'(240 + a);
        it.col = (b < 8) ? 8'(b) : 8'(240 + b);
        case ($urandom_range(0, 7))
          0: it.dval = 24'hFF_FFFF;
          1: it.dval = '0;
          2, 3: it.dval = 24'($urandom_range(0, 1000));
          default: it.dval = 24'($urandom);
        endcase
        pend_q.push_back(it);
      end
    end
    for (int p = 0; p <= 256; p++) begin
      it = blank_item(FN_LOAD_ROUTE);
      it.pi = 9'(p);
      pend_q.push_back(it);
    end
    push_cost(40'd500000000);
    add_random(100);

    write_last_pos(9'd2);
    push_item(FN_SWAP, 1, 2, 0, 0, 1, 1);
    push_item(FN_SWAP, 1, 3, 0, 0, 1, 1);
    push_item(FN_SWAP, 0, 2, 0, 0, 1, 1);
    push_item(FN_TWO_OPT, 1, 3, 0, 0, 1, 1);
    push_item(FN_TWO_OPT, 2, 2, 0, 0, 1, 0);
    push_item(FN_TWO_OPT, 1, 4, 0, 0, 1, 1);
    push_item(FN_OR_OPT, 1, 2, 0, 0, 1, 1);
    push_item(FN_OR_OPT, 2, 1, 0, 0, 2, 1);
    push_item(FN_OR_OPT, 1, 3, 0, 0, 1, 1);
    push_item(FN_OR_OPT, 1, 3, 0, 0, 0, 1);
    push_item(FN_DBRIDGE, 1, 2, 2, 3, 1, 1);
    push_item(FN_DBRIDGE, 1, 3, 2, 4, 1, 1);
    push_item(FN_DBRIDGE, 2, 2, 2, 4, 1, 1);
    push_item(FN_READ_ROUTE, 4, 0, 0, 0, 1, 0);
    push_item(FN_READ_ROUTE, 5, 0, 0, 0, 1, 0);
    push_item(FN_LOAD_ROUTE, 300, 0, 0, 0, 1, 0);
    push_cost(40'hFF_FFFF_FFFF);
    for (int k = 0; k < 3; k++) push_item(FN_DBRIDGE, 1, 3, 2, 4, 1, 1);
    push_cost('0);
    for (int k = 0; k < 3; k++) push_item(FN_DBRIDGE, 1, 3, 2, 4, 1, 1);
    add_random(100);

    write_last_pos(9'd13);
    add_random(100);
    write_last_pos(9'd300);
    add_random(100);
    write_last_pos(9'd100);
    add_random(100);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tme_pkg.sv
rtl/core/tme_ctrl.sv
rtl/core/tme_dpath.sv
rtl/core/tour_move_engine.sv
rtl/core/tme_checker.sv
sim/tour_move_engine_test.sv
